@@ rtl/svbp_pkg.sv @@
// ----------------------------------------------------------------------------
// svbp_pkg
// Shared sizes, codes and helpers for the segmented varint bit packer.
// ----------------------------------------------------------------------------
package svbp_pkg;

  localparam int HELD_DEPTH     = 32;
  localparam int SLOT_DEPTH     = 16;
  localparam int MAX_VALUE_BITS = 32;
  localparam int BYTE_BITS      = 8;
  localparam int OUT_CAP        = 32;

  // byte ring is twice the held depth so emitted bytes survive until drained
  localparam int AW         = $clog2(HELD_DEPTH) + 1;
  localparam int PHYS_DEPTH = 2 ** AW;
  // slot ring
  localparam int SW         = $clog2(SLOT_DEPTH);
  localparam int SLOT_RING  = 2 ** SW;
  localparam int SCW        = $clog2(SLOT_DEPTH + 1);
  localparam int EW         = $clog2(OUT_CAP + 1);
  localparam int KW         = (AW > EW) ? AW : EW;
  // divider operand width
  localparam int DIVW       = 7;

  typedef enum logic [1:0] {
    CMD_PACK  = 2'd0,
    CMD_BIT   = 2'd1,
    CMD_FINAL = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OVF  = 2'd1;
  localparam logic [1:0] STAT_WIDE = 2'd2;

  typedef struct packed {
    logic            start;
    logic [DIVW-1:0] dividend;
    logic [DIVW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DIVW-1:0] quot;
  } div_rsp_t;

  // number of bits needed to hold v
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ rtl/svbp_div.sv @@
// ----------------------------------------------------------------------------
// svbp_div
// Restoring divider, one quotient bit per cycle, shared by the segment math.
// ----------------------------------------------------------------------------
module svbp_div (
  input  logic              clk,
  input  logic              rst,
  input  svbp_pkg::div_req_t req,
  output svbp_pkg::div_rsp_t rsp
);
  import svbp_pkg::*;

  logic            busy;
  logic [2:0]      cnt;
  logic [DIVW-1:0] rem;
  logic [DIVW-1:0] quo;
  logic [DIVW-1:0] dsr;
  logic            done;
  logic [DIVW:0]   shifted;

  assign shifted = {rem, quo[DIVW-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'(DIVW);
      end else if (busy) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      if (shifted >= {1'b0, dsr}) begin
        rem <= DIVW'(shifted - {1'b0, dsr});
        quo <= {quo[DIVW-2:0], 1'b1};
      end else begin
        rem <= DIVW'(shifted);
        quo <= {quo[DIVW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

@@ rtl/segmented_varint_bit_packer.sv @@
// ----------------------------------------------------------------------------
// segmented_varint_bit_packer
// Packs integers and single bits into a byte stream with spare bit slots.
// ----------------------------------------------------------------------------
// operation: a pack runs one or two divider passes, then writes header chunks and
//   value bytes, with flushes between; a bit writes its one header chunk; a width
//   reject and a clear go straight to the status word
// throughput: one item at a time; results then drain one word per cycle while
//   out_ready accepts them, from the registered read port of the byte ring, up to 32 words
// reset: ring head and tail, slot head and counts clear at once, no clearing pass is needed
module segmented_varint_bit_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] value,
  input  logic [5:0]  max_width,
  input  logic [5:0]  segment_hint,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [1:0]  status
);
  import svbp_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_PREP   = 15'b000000000000010,
    ST_DIV1   = 15'b000000000000100,
    ST_SEG    = 15'b000000000001000,
    ST_SEG2   = 15'b000000000010000,
    ST_DIV2   = 15'b000000000100000,
    ST_SEGFIN = 15'b000000001000000,
    ST_HDR    = 15'b000000010000000,
    ST_FLUSH  = 15'b000000100000000,
    ST_VAL    = 15'b000001000000000,
    ST_REM    = 15'b000010000000000,
    ST_SWEEP  = 15'b000100000000000,
    ST_COMMIT = 15'b001000000000000,
    ST_FAIL   = 15'b010000000000000,
    ST_EMIT   = 15'b100000000000000
  } state_t;

  state_t state, ret;
  cmd_t   cmd_q;
  logic [31:0] val_q;
  logic [5:0]  w_q, hint_q;

  // byte ring
  logic [7:0] mem [PHYS_DEPTH];
  logic [7:0] rdata;
  logic       we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] ptr, ptr_next;

  // working state and rollback copy
  logic [AW-1:0]  head, tail, fidx;
  logic [SW-1:0]  shead;
  logic [SCW-1:0] scount;
  logic [2:0]     fstart;
  logic [7:0]     fdata;
  logic [AW-1:0]  snap_head, snap_tail, snap_fidx;
  logic [SW-1:0]  snap_shead;
  logic [SCW-1:0] snap_scount;
  logic [2:0]     snap_fstart;
  logic [7:0]     snap_fdata;

  // slot ring behind the front slot
  logic [AW-1:0] sq_idx   [SLOT_RING];
  logic [2:0]    sq_start [SLOT_RING];
  logic [7:0]    sq_data  [SLOT_RING];

  logic [EW-1:0] e;
  logic [1:0]    status_q;

  // segment math
  logic [2:0]      hbits;
  logic [5:0]      small_q, bigc, ub;
  logic [DIVW-1:0] segs, fin, hv;
  logic [2:0]      hcnt, nb, bidx, rem3;

  // output register
  logic       oval, obv, olast;
  logic [7:0] obyte;
  logic [1:0] ostat;

  div_req_t dreq;
  div_rsp_t drsp;

  svbp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // operand decode
  logic [5:0]      ub_raw, h, small_c, bigc_c, ub1;
  logic [2:0]      hb;
  logic            bad;
  logic [DIVW-1:0] big_c;
  always_comb begin
    ub_raw  = bit_len(val_q);
    h       = (hint_q != 6'd0) ? hint_q : 6'((7'(w_q) + 7'd7) >> 3);
    hb      = 3'(bit_len(32'(h - 6'd1)));
    small_c = w_q >> hb;
    bigc_c  = w_q & 6'((7'd1 << hb) - 7'd1);
    big_c   = DIVW'(small_c) + DIVW'(1);
    ub1     = (ub_raw == 6'd0) ? 6'd1 : ub_raw;
    bad     = (w_q == 6'd0) || (w_q > 6'(MAX_VALUE_BITS)) || (ub_raw > w_q);
  end

  // divider requests
  logic            need_div2;
  logic [DIVW-1:0] big_q;
  always_comb begin
    big_q     = DIVW'(small_q) + DIVW'(1);
    need_div2 = (fin < DIVW'(ub)) && (small_q != 6'd0);
    dreq = '0;
    if (state == ST_PREP && !bad) begin
      dreq.start    = 1'b1;
      dreq.dividend = DIVW'(ub1) + big_c - DIVW'(1);
      dreq.divisor  = big_c;
    end else if (state == ST_SEG2 && need_div2) begin
      dreq.start    = 1'b1;
      dreq.dividend = DIVW'(ub) - fin + DIVW'(small_q) - DIVW'(1);
      dreq.divisor  = DIVW'(small_q);
    end
  end

  // fill levels and flush amount
  logic [AW-1:0] held, tgt;
  logic          held_full;
  logic [KW-1:0] room, k;
  always_comb begin
    held      = tail - head;
    held_full = held >= AW'(HELD_DEPTH);
    tgt       = (scount != '0) ? AW'(fidx - head) : held;
    room      = KW'(OUT_CAP) - KW'(e);
    k         = (KW'(tgt) < room) ? KW'(tgt) : room;
  end

  // header chunk into the front slot
  logic [3:0] room4, wb;
  logic [7:0] chunk, fdata_new;
  logic       fill;
  always_comb begin
    room4     = 4'(BYTE_BITS) - {1'b0, fstart};
    wb        = (room4 < {1'b0, hcnt}) ? room4 : {1'b0, hcnt};
    chunk     = (8'(hv) & 8'((9'd1 << wb) - 9'd1)) << fstart;
    fdata_new = fdata | chunk;
    fill      = ({1'b0, fstart} + wb) == 4'(BYTE_BITS);
  end

  // value byte select and slot ring positions
  logic [2:0]    bsel;
  logic [7:0]    vbyte;
  logic [SW-1:0] nxt, pushpos;
  always_comb begin
    bsel    = (state == ST_REM) ? (nb - 3'd1) : bidx;
    vbyte   = 8'(val_q >> {bsel, 3'b000});
    nxt     = shead + SW'(1);
    pushpos = shead + SW'(scount);
  end

  // ring write port
  always_comb begin
    we    = 1'b0;
    waddr = tail;
    wdata = vbyte;
    case (state)
      ST_HDR: begin
        if (hcnt != 3'd0 && scount != '0 && fill) begin
          we    = 1'b1;
          waddr = fidx;
          wdata = fdata_new;
        end
      end
      ST_VAL: begin
        if (bidx != nb && !held_full) we = 1'b1;
      end
      ST_SWEEP: begin
        if (scount != '0) begin
          we    = 1'b1;
          waddr = fidx;
          wdata = fdata;
        end
      end
      default: we = 1'b0;
    endcase
  end

  // read pointer follows the emission
  always_comb begin
    ptr_next = ptr;
    if (state == ST_COMMIT) ptr_next = snap_head;
    else if (state == ST_EMIT && (!oval || out_ready) && e != '0) ptr_next = ptr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[ptr_next];
    ptr   <= ptr_next;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      shead    <= '0;
      scount   <= '0;
      e        <= '0;
      status_q <= STAT_OK;
      oval     <= 1'b0;
    end else begin
      if (oval && out_ready && state != ST_EMIT) oval <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q       <= cmd_t'(command);
            val_q       <= value;
            w_q         <= max_width;
            hint_q      <= segment_hint;
            snap_head   <= head;
            snap_tail   <= tail;
            snap_shead  <= shead;
            snap_scount <= scount;
            snap_fidx   <= fidx;
            snap_fstart <= fstart;
            snap_fdata  <= fdata;
            e           <= '0;
            status_q    <= STAT_OK;
            case (cmd_t'(command))
              CMD_PACK:  state <= ST_PREP;
              CMD_BIT: begin
                hv    <= DIVW'(value[0]);
                hcnt  <= 3'd1;
                state <= ST_HDR;
              end
              CMD_FINAL: state <= ST_SWEEP;
              default: begin
                head   <= '0;
                tail   <= '0;
                shead  <= '0;
                scount <= '0;
                state  <= ST_EMIT;
              end
            endcase
          end
        end
        ST_PREP: begin
          if (bad) begin
            status_q <= STAT_WIDE;
            state    <= ST_EMIT;
          end else begin
            hbits   <= hb;
            small_q <= small_c;
            bigc    <= bigc_c;
            ub      <= ub1;
            state   <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (drsp.done) begin
            segs  <= (drsp.quot < DIVW'(bigc)) ? drsp.quot : DIVW'(bigc);
            state <= ST_SEG;
          end
        end
        ST_SEG: begin
          fin   <= DIVW'(segs * big_q);
          state <= ST_SEG2;
        end
        ST_SEG2: state <= need_div2 ? ST_DIV2 : ST_SEGFIN;
        ST_DIV2: begin
          if (drsp.done) begin
            segs  <= segs + drsp.quot;
            fin   <= fin + DIVW'(drsp.quot * small_q);
            state <= ST_SEGFIN;
          end
        end
        ST_SEGFIN: begin
          hv    <= segs - DIVW'(1);
          hcnt  <= hbits;
          nb    <= 3'((fin + DIVW'(7)) >> 3);
          rem3  <= fin[2:0];
          bidx  <= 3'd0;
          state <= ST_HDR;
        end
        // header bits go into spare slots, a fresh byte when none is left
        ST_HDR: begin
          if (hcnt == 3'd0) begin
            state <= (cmd_q == CMD_PACK) ? ST_VAL : ST_COMMIT;
          end else if (scount == '0) begin
            if (held_full) begin
              state <= ST_FAIL;
            end else begin
              fidx   <= tail;
              fstart <= 3'd0;
              fdata  <= 8'd0;
              scount <= SCW'(1);
              tail   <= tail + AW'(1);
            end
          end else begin
            hv   <= hv >> wb;
            hcnt <= hcnt - 3'(wb);
            if (fill) begin
              scount <= scount - SCW'(1);
              shead  <= nxt;
              fidx   <= sq_idx[nxt];
              fstart <= sq_start[nxt];
              fdata  <= sq_data[nxt];
              ret    <= ST_HDR;
              state  <= ST_FLUSH;
            end else begin
              fstart <= 3'(fstart + 3'(wb));
              fdata  <= fdata_new;
            end
          end
        end
        ST_FLUSH: begin
          head  <= head + AW'(k);
          e     <= e + EW'(k);
          state <= ret;
        end
        ST_VAL: begin
          if (bidx == nb) begin
            state <= ST_REM;
          end else if (held_full) begin
            state <= ST_FAIL;
          end else begin
            tail <= tail + AW'(1);
            bidx <= bidx + 3'd1;
          end
        end
        // top bits of the last value byte become a spare slot
        ST_REM: begin
          if (rem3 == 3'd0) begin
            ret   <= ST_COMMIT;
            state <= ST_FLUSH;
          end else if (scount >= SCW'(SLOT_DEPTH)) begin
            state <= ST_FAIL;
          end else begin
            if (scount == '0) begin
              fidx   <= tail - AW'(1);
              fstart <= rem3;
              fdata  <= vbyte;
            end else begin
              sq_idx[pushpos]   <= tail - AW'(1);
              sq_start[pushpos] <= rem3;
              sq_data[pushpos]  <= vbyte;
            end
            scount <= scount + SCW'(1);
            ret    <= ST_COMMIT;
            state  <= ST_FLUSH;
          end
        end
        // finalize: write back every open slot byte, then flush
        ST_SWEEP: begin
          if (scount == '0) begin
            ret   <= ST_COMMIT;
            state <= ST_FLUSH;
          end else begin
            scount <= scount - SCW'(1);
            shead  <= nxt;
            fidx   <= sq_idx[nxt];
            fstart <= sq_start[nxt];
            fdata  <= sq_data[nxt];
          end
        end
        ST_COMMIT: state <= ST_EMIT;
        ST_FAIL: begin
          head     <= snap_head;
          tail     <= snap_tail;
          shead    <= snap_shead;
          scount   <= snap_scount;
          fidx     <= snap_fidx;
          fstart   <= snap_fstart;
          fdata    <= snap_fdata;
          e        <= '0;
          status_q <= STAT_OVF;
          state    <= ST_EMIT;
        end
        // drain emitted words, or one status word when none
        ST_EMIT: begin
          if (!oval || out_ready) begin
            oval <= 1'b1;
            if (e == '0) begin
              obyte <= 8'd0;
              obv   <= 1'b0;
              olast <= 1'b1;
              ostat <= status_q;
              state <= ST_IDLE;
            end else begin
              obyte <= rdata;
              obv   <= 1'b1;
              olast <= (e == EW'(1));
              ostat <= STAT_OK;
              e     <= e - EW'(1);
              if (e == EW'(1)) state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = oval;
  assign out_byte   = obyte;
  assign byte_valid = obv;
  assign last       = olast;
  assign status     = ostat;

  // checks
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    scount <= SCW'(SLOT_DEPTH)) else $error("slot count beyond depth");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (held <= AW'(HELD_DEPTH))) else $error("held bytes beyond depth");
  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    e <= EW'(OUT_CAP)) else $error("emit count beyond cap");
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (oval && obv) |-> (ostat == STAT_OK)) else $error("byte word with status");
  a_stat_last: assert property (@(posedge clk) disable iff (rst)
    (oval && !obv) |-> olast) else $error("status word not last");

endmodule
